### sv/nbody_gravity_euler_step_defines.svh
// Assertion macros shared by the n-body step RTL.
`ifndef NBODY_GRAVITY_EULER_STEP_DEFINES_SVH
`define NBODY_GRAVITY_EULER_STEP_DEFINES_SVH

// Same-cycle implication, checked on clk and off during reset.
`define NBGE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk and off during reset.
`define NBGE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/nbge_pkg.sv
// Types, constants and helper functions of the n-body step block.
package nbge_pkg;

  localparam int MAX_BODIES = 8;
  localparam int FRAC_BITS  = 16;
  localparam int SLOT_W     = 3;
  localparam int IDX_W      = $clog2(MAX_BODIES);
  localparam int CNT_W      = IDX_W + 1;
  localparam int POS_AW     = IDX_W + 1;
  localparam int POS_W      = 96;
  localparam int VEL_W      = 97;
  localparam int CFG_AW     = 4;
  localparam int ITER_W     = 6;

  localparam int SQRT_ITERS = 33;
  localparam int DIVK_ITERS = 48;
  localparam int DIVU_ITERS = 18;

  localparam logic [31:0] GAIN_RST = 32'd6553600;
  localparam logic [23:0] DT_RST   = 24'd655;
  localparam logic [31:0] MIN_RST  = 32'd6554;

  localparam logic [47:0]        ACC_MAX  = {1'b0, {47{1'b1}}};
  localparam logic signed [48:0] ACC_HI   = {2'b00, {47{1'b1}}};
  localparam logic signed [48:0] ACC_LO   = -ACC_HI;
  localparam logic [40:0]        STEP_CAP = {1'b1, 40'd0};

  typedef enum logic [1:0] {
    REG_GAIN  = 2'd0,
    REG_DT    = 2'd1,
    REG_MIN   = 2'd2,
    REG_PAUSE = 2'd3
  } reg_idx_t;

  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_TICK = 1'b1
  } req_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_BODY_SEL,
    ST_BODY_LAT,
    ST_PAIR_SEL,
    ST_PAIR_LAT,
    ST_SQ_MUL,
    ST_SQ_ACC,
    ST_DIST_CHK,
    ST_SQRT,
    ST_DIVK,
    ST_DIVU_INIT,
    ST_DIVU,
    ST_ACC_MUL,
    ST_ACC_ADD,
    ST_VEL_MUL,
    ST_VEL_ADD,
    ST_POS_MUL,
    ST_POS_ADD,
    ST_WRITE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic               req_type;
    logic [SLOT_W-1:0]  slot;
    logic signed [31:0] load_pos_x;
    logic signed [31:0] load_pos_y;
    logic signed [31:0] load_pos_z;
    logic signed [31:0] load_vel_x;
    logic signed [31:0] load_vel_y;
    logic signed [31:0] load_vel_z;
    logic               stays_fixed;
  } nbge_in_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  out_slot;
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_pos_z;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic signed [31:0] new_vel_z;
    logic               clipped;
    logic               last_of_run;
  } nbge_out_t;

  // Returns {saturated, value} of v limited to the signed 32-bit range.
  function automatic logic [32:0] sat32(input logic signed [41:0] v);
    logic [32:0] r;
    if (v > 42'sd2147483647) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (v < -42'sd2147483648) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

endpackage

### sv/nbge_in_if.sv
// Valid/ready channel that carries one request item into the block.
interface nbge_in_if;
  import nbge_pkg::*;
  logic     valid;
  logic     ready;
  nbge_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### sv/nbge_out_if.sv
// Valid/ready channel that carries one body result item out of the block.
interface nbge_out_if;
  import nbge_pkg::*;
  logic      valid;
  logic      ready;
  nbge_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### sv/nbody_gravity_euler_step.sv
// N-body gravity step in fixed point: body store, pair sequencer and shared arithmetic.
//
// The block keeps up to eight bodies in Q16.16 fixed point. Items arrive on
// in_ch; a load item writes one slot and marks it active, and it is taken
// with no result. A tick item walks every active slot in order and sends one
// result item per active body on out_ch, the last one flagged with
// last_of_run. Four registers (gain, time step, minimum squared distance and
// pause) sit behind the cfg_ APB port; the user must write them only while
// the block is idle, which the block itself does not enforce. A tick runs on
// one sequencer that shares a single 24x33 multiplier and one restoring
// shift-subtract unit for the square root and both divisions. in_ch.ready
// is low for the whole tick. Results go through an output register, so the
// next body is computed while a result waits; a stalled receiver only holds
// the sequencer when a second result is ready to go. Reset clears the active
// flags, the registers and the handshake state; the body store needs no pass.
// New positions go to a second position bank so pairs keep using the old ones.
`include "nbody_gravity_euler_step_defines.svh"

module nbody_gravity_euler_step (
  input  logic                        clk,
  input  logic                        rst_n,
  nbge_in_if.sink                     in_ch,
  nbge_out_if.source                  out_ch,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [nbge_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);
  import nbge_pkg::*;

  // Configuration registers.
  logic [31:0] gain_r;
  logic [23:0] dt_r;
  logic [31:0] min_r;
  logic        pause_r;
  reg_idx_t    cfg_idx;
  logic        cfg_we;

  // Sequencer state and counters.
  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    i_r, i_nxt;
  logic [CNT_W-1:0]    j_r, j_nxt;
  logic [1:0]          ax_r, ax_nxt;
  logic [ITER_W-1:0]   cnt_r, cnt_nxt;
  logic                ph_r, ph_nxt;
  logic                bsel_r, bsel_nxt;
  logic [MAX_BODIES-1:0] active_r, active_nxt;
  logic [IDX_W-1:0]    last_r, last_nxt;

  // Per-body working values.
  logic signed [31:0] pi_r [3];
  logic signed [31:0] pi_nxt [3];
  logic signed [31:0] np_r [3];
  logic signed [31:0] np_nxt [3];
  logic signed [31:0] nv_r [3];
  logic signed [31:0] nv_nxt [3];
  logic               fixed_i_r, fixed_i_nxt;
  logic               clip_r, clip_nxt;
  logic signed [47:0] acc_r [3];
  logic signed [47:0] acc_nxt [3];

  // Per-pair working values.
  logic [31:0] dmag_r [3];
  logic [31:0] dmag_nxt [3];
  logic [2:0]  dneg_r, dneg_nxt;
  logic [65:0] q_r, q_nxt;
  logic [32:0] r_r, r_nxt;
  logic [47:0] k_r, k_nxt;
  logic [17:0] u_r, u_nxt;

  // Shift-subtract unit.
  logic [51:0] rem_r, rem_nxt;
  logic [47:0] quo_r, quo_nxt;
  logic [65:0] src_r, src_nxt;
  logic [49:0] div_r, div_nxt;
  logic [52:0] rem_sh, trial, step_rem;
  logic        step_ge;
  logic [47:0] step_quo;

  // Multiplier.
  logic [47:0] mul_a;
  logic [32:0] mul_b;
  logic [23:0] mul_chunk;
  logic [56:0] pp;
  logic [80:0] prod_r, prod_nxt;
  logic [64:0] prod_sh;

  // Accumulate and update datapath.
  logic               pair_sat;
  logic [47:0]        a_mag;
  logic signed [48:0] a_term, acc_sum;
  logic [47:0]        acc_new;
  logic               acc_sat;
  logic               step_sat;
  logic [40:0]        m_mag;
  logic signed [41:0] upd_base, upd_delta, upd_sum;
  logic               upd_neg;
  logic [32:0]        upd_clamp;
  logic [47:0]        acc_mag;
  logic [31:0]        nv_mag;
  logic signed [32:0] diff [3];

  // Body store: two position banks and one velocity bank.
  logic [POS_W-1:0]  pos_mem [2*MAX_BODIES];
  logic [VEL_W-1:0]  vel_mem [MAX_BODIES];
  logic [POS_W-1:0]  pos_rd_r;
  logic [VEL_W-1:0]  vel_rd_r;
  logic              pos_we, vel_we;
  logic [POS_AW-1:0] pos_wa, pos_ra;
  logic [IDX_W-1:0]  vel_wa, vel_ra;
  logic [POS_W-1:0]  pos_wd;
  logic [VEL_W-1:0]  vel_wd;

  // Output register.
  logic      out_valid_r, out_valid_nxt;
  nbge_out_t out_data_r, out_data_nxt;

  // ---------------------------------------------------------------------------
  // Configuration port. Every write completes in its access cycle.
  // ---------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[3:2]);
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r  <= GAIN_RST;
      dt_r    <= DT_RST;
      min_r   <= MIN_RST;
      pause_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_GAIN:  gain_r  <= cfg_pwdata;
        REG_DT:    dt_r    <= cfg_pwdata[23:0];
        REG_MIN:   min_r   <= cfg_pwdata;
        REG_PAUSE: pause_r <= cfg_pwdata[0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_GAIN:  cfg_prdata = gain_r;
      REG_DT:    cfg_prdata = {8'd0, dt_r};
      REG_MIN:   cfg_prdata = min_r;
      REG_PAUSE: cfg_prdata = {31'd0, pause_r};
    endcase
  end

  // ---------------------------------------------------------------------------
  // Body store with registered reads.
  // ---------------------------------------------------------------------------
  assign pos_ra = (state_r == ST_BODY_SEL) ? {bsel_r, i_r[IDX_W-1:0]}
                                           : {bsel_r, j_r[IDX_W-1:0]};
  assign vel_ra = i_r[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[pos_wa] <= pos_wd;
    end
    pos_rd_r <= pos_mem[pos_ra];
  end

  always_ff @(posedge clk) begin
    if (vel_we) begin
      vel_mem[vel_wa] <= vel_wd;
    end
    vel_rd_r <= vel_mem[vel_ra];
  end

  // ---------------------------------------------------------------------------
  // Shared shift-subtract step: two radicand bits per cycle for the square
  // root, one dividend bit per cycle for a division.
  // ---------------------------------------------------------------------------
  always_comb begin
    if (state_r == ST_SQRT) begin
      rem_sh = {rem_r[50:0], src_r[65:64]};
      trial  = {18'd0, quo_r[32:0], 2'b01};
    end else begin
      rem_sh = {rem_r, src_r[65]};
      trial  = {3'd0, div_r};
    end
    step_ge  = (rem_sh >= trial);
    step_rem = step_ge ? (rem_sh - trial) : rem_sh;
    step_quo = {quo_r[46:0], step_ge};
  end

  // ---------------------------------------------------------------------------
  // Shared multiplier: the 48-bit operand goes in two 24-bit halves.
  // ---------------------------------------------------------------------------
  always_comb begin
    acc_mag = acc_r[ax_r][47] ? 48'(-acc_r[ax_r]) : 48'(acc_r[ax_r]);
    nv_mag  = nv_r[ax_r][31] ? 32'(-nv_r[ax_r]) : 32'(nv_r[ax_r]);
    unique case (state_r)
      ST_SQ_MUL: begin
        mul_a = {16'd0, dmag_r[ax_r]};
        mul_b = {1'b0, dmag_r[ax_r]};
      end
      ST_ACC_MUL: begin
        mul_a = k_r;
        mul_b = {15'd0, u_r};
      end
      ST_VEL_MUL: begin
        mul_a = acc_mag;
        mul_b = {9'd0, dt_r};
      end
      default: begin
        mul_a = {16'd0, nv_mag};
        mul_b = {9'd0, dt_r};
      end
    endcase
    mul_chunk = ph_r ? mul_a[47:24] : mul_a[23:0];
    pp        = {33'd0, mul_chunk} * {24'd0, mul_b};
    prod_sh   = prod_r[80:FRAC_BITS];
  end

  // ---------------------------------------------------------------------------
  // Pair acceleration accumulate and the Euler update adder.
  // ---------------------------------------------------------------------------
  always_comb begin
    pair_sat = (prod_sh > 65'(ACC_MAX));
    a_mag    = pair_sat ? ACC_MAX : prod_sh[47:0];
    a_term   = {1'b0, a_mag};
    if (dneg_r[ax_r]) begin
      a_term = -a_term;
    end
    acc_sum = {acc_r[ax_r][47], acc_r[ax_r]} + a_term;
    if (acc_sum > ACC_HI) begin
      acc_new = ACC_HI[47:0];
      acc_sat = 1'b1;
    end else if (acc_sum < ACC_LO) begin
      acc_new = ACC_LO[47:0];
      acc_sat = 1'b1;
    end else begin
      acc_new = acc_sum[47:0];
      acc_sat = 1'b0;
    end

    step_sat = (prod_sh > 65'(STEP_CAP));
    m_mag    = step_sat ? STEP_CAP : prod_sh[40:0];
    if (state_r == ST_VEL_ADD) begin
      upd_base = {{10{nv_r[ax_r][31]}}, nv_r[ax_r]};
      upd_neg  = acc_r[ax_r][47];
    end else begin
      upd_base = {{10{np_r[ax_r][31]}}, np_r[ax_r]};
      upd_neg  = nv_r[ax_r][31];
    end
    upd_delta = {1'b0, m_mag};
    upd_sum   = upd_neg ? (upd_base - upd_delta) : (upd_base + upd_delta);
    upd_clamp = sat32(upd_sum);
  end

  // Position differences of the current pair, one per axis.
  always_comb begin
    for (int ax = 0; ax < 3; ax++) begin
      diff[ax] = {pos_rd_r[ax*32+31], pos_rd_r[ax*32 +: 32]} - {pi_r[ax][31], pi_r[ax]};
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: next state and datapath control.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    ax_nxt        = ax_r;
    cnt_nxt       = cnt_r;
    ph_nxt        = ph_r;
    bsel_nxt      = bsel_r;
    active_nxt    = active_r;
    last_nxt      = last_r;
    pi_nxt        = pi_r;
    np_nxt        = np_r;
    nv_nxt        = nv_r;
    fixed_i_nxt   = fixed_i_r;
    clip_nxt      = clip_r;
    acc_nxt       = acc_r;
    dmag_nxt      = dmag_r;
    dneg_nxt      = dneg_r;
    q_nxt         = q_r;
    r_nxt         = r_r;
    k_nxt         = k_r;
    u_nxt         = u_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    src_nxt       = src_r;
    div_nxt       = div_r;
    prod_nxt      = prod_r;
    pos_we        = 1'b0;
    pos_wa        = {~bsel_r, i_r[IDX_W-1:0]};
    pos_wd        = {np_r[2], np_r[1], np_r[0]};
    vel_we        = 1'b0;
    vel_wa        = i_r[IDX_W-1:0];
    vel_wd        = {fixed_i_r, nv_r[2], nv_r[1], nv_r[0]};
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          if (req_t'(in_ch.data.req_type) == REQ_TICK) begin
            i_nxt = '0;
            for (int b = 0; b < MAX_BODIES; b++) begin
              if (active_r[b]) begin
                last_nxt = IDX_W'(b);
              end
            end
            state_nxt = ST_BODY_SEL;
          end else if (32'(in_ch.data.slot) < MAX_BODIES) begin
            pos_we = 1'b1;
            pos_wa = {bsel_r, in_ch.data.slot[IDX_W-1:0]};
            pos_wd = {in_ch.data.load_pos_z, in_ch.data.load_pos_y, in_ch.data.load_pos_x};
            vel_we = 1'b1;
            vel_wa = in_ch.data.slot[IDX_W-1:0];
            vel_wd = {in_ch.data.stays_fixed, in_ch.data.load_vel_z,
                      in_ch.data.load_vel_y, in_ch.data.load_vel_x};
            active_nxt[in_ch.data.slot[IDX_W-1:0]] = 1'b1;
          end
        end
      end

      ST_BODY_SEL: begin
        if (i_r == CNT_W'(MAX_BODIES)) begin
          bsel_nxt  = ~bsel_r;
          state_nxt = ST_IDLE;
        end else if (!active_r[i_r[IDX_W-1:0]]) begin
          i_nxt = i_r + 1'b1;
        end else begin
          state_nxt = ST_BODY_LAT;
        end
      end

      ST_BODY_LAT: begin
        for (int ax = 0; ax < 3; ax++) begin
          pi_nxt[ax]  = pos_rd_r[ax*32 +: 32];
          np_nxt[ax]  = pos_rd_r[ax*32 +: 32];
          nv_nxt[ax]  = vel_rd_r[ax*32 +: 32];
          acc_nxt[ax] = '0;
        end
        fixed_i_nxt = vel_rd_r[VEL_W-1];
        clip_nxt    = 1'b0;
        j_nxt       = '0;
        if (pause_r || vel_rd_r[VEL_W-1]) begin
          state_nxt = ST_WRITE;
        end else begin
          state_nxt = ST_PAIR_SEL;
        end
      end

      ST_PAIR_SEL: begin
        if (j_r == CNT_W'(MAX_BODIES)) begin
          ax_nxt    = '0;
          ph_nxt    = 1'b0;
          state_nxt = ST_VEL_MUL;
        end else if (j_r == i_r || !active_r[j_r[IDX_W-1:0]]) begin
          j_nxt = j_r + 1'b1;
        end else begin
          state_nxt = ST_PAIR_LAT;
        end
      end

      ST_PAIR_LAT: begin
        for (int ax = 0; ax < 3; ax++) begin
          dneg_nxt[ax] = diff[ax][32];
          dmag_nxt[ax] = diff[ax][32] ? 32'(-diff[ax]) : diff[ax][31:0];
        end
        q_nxt     = '0;
        ax_nxt    = '0;
        ph_nxt    = 1'b0;
        state_nxt = ST_SQ_MUL;
      end

      ST_SQ_MUL, ST_ACC_MUL, ST_VEL_MUL, ST_POS_MUL: begin
        if (!ph_r) begin
          prod_nxt = {24'd0, pp};
        end else begin
          prod_nxt = prod_r + {pp, 24'd0};
        end
        ph_nxt = ~ph_r;
        if (ph_r) begin
          priority case (state_r)
            ST_SQ_MUL:  state_nxt = ST_SQ_ACC;
            ST_ACC_MUL: state_nxt = ST_ACC_ADD;
            ST_VEL_MUL: state_nxt = ST_VEL_ADD;
            default:    state_nxt = ST_POS_ADD;
          endcase
        end
      end

      ST_SQ_ACC: begin
        q_nxt = q_r + prod_r[65:0];
        if (ax_r == 2'd2) begin
          state_nxt = ST_DIST_CHK;
        end else begin
          ax_nxt    = ax_r + 1'b1;
          state_nxt = ST_SQ_MUL;
        end
      end

      ST_DIST_CHK: begin
        if (q_r[65:FRAC_BITS] == '0 || q_r[65:FRAC_BITS] < {18'd0, min_r}) begin
          j_nxt     = j_r + 1'b1;
          state_nxt = ST_PAIR_SEL;
        end else begin
          rem_nxt   = '0;
          quo_nxt   = '0;
          src_nxt   = q_r;
          cnt_nxt   = ITER_W'(SQRT_ITERS - 1);
          state_nxt = ST_SQRT;
        end
      end

      ST_SQRT: begin
        rem_nxt = step_rem[51:0];
        quo_nxt = step_quo;
        src_nxt = {src_r[63:0], 2'b00};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          r_nxt     = step_quo[32:0];
          rem_nxt   = '0;
          quo_nxt   = '0;
          src_nxt   = {gain_r, 34'd0};
          div_nxt   = q_r[65:FRAC_BITS];
          cnt_nxt   = ITER_W'(DIVK_ITERS - 1);
          state_nxt = ST_DIVK;
        end
      end

      ST_DIVK: begin
        rem_nxt = step_rem[51:0];
        quo_nxt = step_quo;
        src_nxt = {src_r[64:0], 1'b0};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          k_nxt     = step_quo;
          ax_nxt    = '0;
          state_nxt = ST_DIVU_INIT;
        end
      end

      ST_DIVU_INIT: begin
        // The quotient stays below 2^18, so the top dividend bits start as
        // the partial remainder.
        rem_nxt   = {22'd0, dmag_r[ax_r][31:2]};
        src_nxt   = {dmag_r[ax_r][1:0], 64'd0};
        div_nxt   = {17'd0, r_r};
        quo_nxt   = '0;
        cnt_nxt   = ITER_W'(DIVU_ITERS - 1);
        state_nxt = ST_DIVU;
      end

      ST_DIVU: begin
        rem_nxt = step_rem[51:0];
        quo_nxt = step_quo;
        src_nxt = {src_r[64:0], 1'b0};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          u_nxt     = step_quo[17:0];
          ph_nxt    = 1'b0;
          state_nxt = ST_ACC_MUL;
        end
      end

      ST_ACC_ADD: begin
        acc_nxt[ax_r] = acc_new;
        clip_nxt      = clip_r | pair_sat | acc_sat;
        if (ax_r == 2'd2) begin
          j_nxt     = j_r + 1'b1;
          state_nxt = ST_PAIR_SEL;
        end else begin
          ax_nxt    = ax_r + 1'b1;
          state_nxt = ST_DIVU_INIT;
        end
      end

      ST_VEL_ADD: begin
        nv_nxt[ax_r] = upd_clamp[31:0];
        clip_nxt     = clip_r | step_sat | upd_clamp[32];
        ph_nxt       = 1'b0;
        state_nxt    = ST_POS_MUL;
      end

      ST_POS_ADD: begin
        np_nxt[ax_r] = upd_clamp[31:0];
        clip_nxt     = clip_r | step_sat | upd_clamp[32];
        ph_nxt       = 1'b0;
        if (ax_r == 2'd2) begin
          state_nxt = ST_WRITE;
        end else begin
          ax_nxt    = ax_r + 1'b1;
          state_nxt = ST_VEL_MUL;
        end
      end

      ST_WRITE: begin
        pos_we    = 1'b1;
        vel_we    = 1'b1;
        state_nxt = ST_EMIT;
      end

      ST_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.out_slot    = SLOT_W'(i_r[IDX_W-1:0]);
          out_data_nxt.new_pos_x   = np_r[0];
          out_data_nxt.new_pos_y   = np_r[1];
          out_data_nxt.new_pos_z   = np_r[2];
          out_data_nxt.new_vel_x   = nv_r[0];
          out_data_nxt.new_vel_y   = nv_r[1];
          out_data_nxt.new_vel_z   = nv_r[2];
          out_data_nxt.clipped     = clip_r;
          out_data_nxt.last_of_run = (i_r[IDX_W-1:0] == last_r);
          i_nxt                    = i_r + 1'b1;
          state_nxt                = ST_BODY_SEL;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      active_r    <= '0;
      bsel_r      <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      ax_r        <= '0;
      cnt_r       <= '0;
      ph_r        <= 1'b0;
      last_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      active_r    <= active_nxt;
      bsel_r      <= bsel_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      ax_r        <= ax_nxt;
      cnt_r       <= cnt_nxt;
      ph_r        <= ph_nxt;
      last_r      <= last_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    pi_r       <= pi_nxt;
    np_r       <= np_nxt;
    nv_r       <= nv_nxt;
    fixed_i_r  <= fixed_i_nxt;
    clip_r     <= clip_nxt;
    acc_r      <= acc_nxt;
    dmag_r     <= dmag_nxt;
    dneg_r     <= dneg_nxt;
    q_r        <= q_nxt;
    r_r        <= r_nxt;
    k_r        <= k_nxt;
    u_r        <= u_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    src_r      <= src_nxt;
    div_r      <= div_nxt;
    prod_r     <= prod_nxt;
    out_data_r <= out_data_nxt;
  end

  // The acceleration sums stay inside their saturation range between pairs.
  `NBGE_ASSERT_NOW(a_acc_bound, state_r == ST_PAIR_SEL && j_r != '0,
    acc_r[0] <= ACC_HI && acc_r[0] >= ACC_LO && acc_r[1] <= ACC_HI &&
    acc_r[1] >= ACC_LO && acc_r[2] <= ACC_HI && acc_r[2] >= ACC_LO,
    "acceleration sum out of range")
  // A restoring division keeps its partial remainder below the divisor.
  `NBGE_ASSERT_NOW(a_div_rem, state_r == ST_DIVU || state_r == ST_DIVK,
    rem_r < {2'd0, div_r}, "division remainder not below divisor")
  // Finishing a tick switches the position bank.
  `NBGE_ASSERT_NEXT(a_bank_flip, state_r == ST_BODY_SEL && i_r == CNT_W'(MAX_BODIES),
    bsel_r != $past(bsel_r) && state_r == ST_IDLE, "position bank did not switch")

endmodule

### dv/testbench.sv
// Self-checking testbench for the n-body gravity step block with a built-in predictor.
`timescale 1ns / 1ps

module testbench;
  import nbge_pkg::*;

  // The clock period is 12 ns.
  localparam int HALF_PERIOD = 6;
  // A stall can last this many cycles with no item moving on either channel.
  localparam int STALL_LIMIT = 40000;
  // The number of cycles to let the block settle after the last result.
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 28;

  logic clk;
  logic rst_n;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  nbge_in_if  req_ch ();
  nbge_out_if body_ch ();

  nbody_gravity_euler_step DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (req_ch.sink),
    .out_ch      (body_ch.source),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // This is the predictor's own copy of the registers and the body table.
  logic [31:0] gain_q;
  logic [23:0] dt_q;
  logic [31:0] min_sq_q;
  logic        paused_q;
  int          body_pos [MAX_BODIES][3];
  int          body_vel [MAX_BODIES][3];
  bit          body_pinned [MAX_BODIES];
  bit          body_live [MAX_BODIES];

  nbge_in_t  pending_items [$];
  nbge_out_t expected_bodies [$];
  int        mismatch_count;
  bit        idling_on;
  int        req_gap;
  int        body_gap;
  int        stall_cycles;

  initial begin
    clk = 1'b0;
    forever #HALF_PERIOD clk = ~clk;
  end

  // The product floor(x * m / 2^F) is limited to cap, and the saturation is recorded.
  function automatic logic [63:0] scale_q(input logic [63:0] x, input logic [31:0] m,
                                          input logic [63:0] cap, inout bit sat);
    logic [127:0] p;
    p = ({64'd0, x} * {96'd0, m}) >> FRAC_BITS;
    if (p > {64'd0, cap}) begin
      sat = 1'b1;
      return cap;
    end
    return p[63:0];
  endfunction

  // This is the integer square root of a 66-bit value, found one bit at a time.
  function automatic logic [33:0] root66(input logic [65:0] q);
    logic [33:0] r;
    logic [69:0] t;
    r = '0;
    for (int b = 33; b >= 0; b--) begin
      t = {36'd0, r | (34'd1 << b)};
      if (t * t <= {4'd0, q}) r = r | (34'd1 << b);
    end
    return r;
  endfunction

  function automatic int clamp_word(input longint v, inout bit sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 32'sh7FFF_FFFF;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return 32'sh8000_0000;
    end
    return int'(v);
  endfunction

  // This sums the pull of every other live body on body i, using the positions from before the tick.
  function automatic void pull_on(input int i, output longint acc [3], inout bit sat);
    longint      d [3];
    logic [63:0] mag [3];
    logic [65:0] q;
    logic [63:0] s;
    logic [63:0] k;
    logic [63:0] u;
    logic [63:0] a;
    logic [33:0] r;
    longint      t;
    for (int ax = 0; ax < 3; ax++) acc[ax] = 0;
    for (int j = 0; j < MAX_BODIES; j++) begin
      if (j == i || !body_live[j]) continue;
      q = '0;
      for (int ax = 0; ax < 3; ax++) begin
        d[ax] = longint'(body_pos[j][ax]) - longint'(body_pos[i][ax]);
        mag[ax] = (d[ax] < 0) ? 64'(-d[ax]) : 64'(d[ax]);
        q = q + {2'b00, mag[ax] * mag[ax]};
      end
      s = 64'(q >> FRAC_BITS);
      // A pair at zero distance is skipped even when the threshold is zero.
      if (s == 0 || s < {32'd0, min_sq_q}) continue;
      r = root66(q);
      k = {16'd0, gain_q, 16'd0} / s;
      for (int ax = 0; ax < 3; ax++) begin
        u = (mag[ax] << FRAC_BITS) / {30'd0, r};
        a = scale_q(k, u[31:0], {16'd0, ACC_MAX}, sat);
        t = acc[ax] + ((d[ax] < 0) ? -longint'(a) : longint'(a));
        if (t > longint'(ACC_MAX)) begin
          t = longint'(ACC_MAX);
          sat = 1'b1;
        end else if (t < -longint'(ACC_MAX)) begin
          t = -longint'(ACC_MAX);
          sat = 1'b1;
        end
        acc[ax] = t;
      end
    end
  endfunction

  // A tick advances every live body that is neither pinned nor paused, then reports all live bodies.
  function automatic void predict_tick();
    int        np [MAX_BODIES][3];
    int        nv [MAX_BODIES][3];
    bit        clip [MAX_BODIES];
    int        last;
    longint    acc [3];
    longint    v;
    longint    p;
    logic [63:0] m;
    nbge_out_t res;
    last = -1;
    for (int i = 0; i < MAX_BODIES; i++) begin
      clip[i] = 1'b0;
      if (!body_live[i]) continue;
      for (int ax = 0; ax < 3; ax++) begin
        np[i][ax] = body_pos[i][ax];
        nv[i][ax] = body_vel[i][ax];
      end
      if (!paused_q && !body_pinned[i]) begin
        pull_on(i, acc, clip[i]);
        for (int ax = 0; ax < 3; ax++) begin
          // Velocity is updated first, and the new velocity moves the position.
          m = scale_q((acc[ax] < 0) ? 64'(-acc[ax]) : 64'(acc[ax]), {8'd0, dt_q},
                      {23'd0, STEP_CAP}, clip[i]);
          v = longint'(nv[i][ax]);
          v = (acc[ax] < 0) ? v - longint'(m) : v + longint'(m);
          nv[i][ax] = clamp_word(v, clip[i]);
          v = longint'(nv[i][ax]);
          m = scale_q((v < 0) ? 64'(-v) : 64'(v), {8'd0, dt_q}, {23'd0, STEP_CAP}, clip[i]);
          p = longint'(np[i][ax]);
          p = (v < 0) ? p - longint'(m) : p + longint'(m);
          np[i][ax] = clamp_word(p, clip[i]);
        end
      end
      last = i;
    end
    for (int i = 0; i < MAX_BODIES; i++) begin
      if (!body_live[i]) continue;
      for (int ax = 0; ax < 3; ax++) begin
        body_pos[i][ax] = np[i][ax];
        body_vel[i][ax] = nv[i][ax];
      end
      res.out_slot    = SLOT_W'(i);
      res.new_pos_x   = np[i][0];
      res.new_pos_y   = np[i][1];
      res.new_pos_z   = np[i][2];
      res.new_vel_x   = nv[i][0];
      res.new_vel_y   = nv[i][1];
      res.new_vel_z   = nv[i][2];
      res.clipped     = clip[i];
      res.last_of_run = (i == last);
      expected_bodies.push_back(res);
    end
  endfunction

  function automatic void apply_item(input nbge_in_t it);
    int s;
    if (it.req_type == REQ_TICK) begin
      predict_tick();
    end else begin
      s = int'(it.slot);
      if (s < MAX_BODIES) begin
        body_pos[s][0] = it.load_pos_x;
        body_pos[s][1] = it.load_pos_y;
        body_pos[s][2] = it.load_pos_z;
        body_vel[s][0] = it.load_vel_x;
        body_vel[s][1] = it.load_vel_y;
        body_vel[s][2] = it.load_vel_z;
        body_pinned[s] = it.stays_fixed;
        body_live[s] = 1'b1;
      end
    end
  endfunction

  // The request driver and the input-side monitor share one clocked block.
  always @(posedge clk) begin
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
      req_gap = 0;
    end else begin
      if (req_ch.valid && req_ch.ready) apply_item(req_ch.data);
      if (req_ch.valid && !req_ch.ready) begin
        // The current item is held until the block takes it.
      end else if (req_gap > 0) begin
        req_gap--;
        req_ch.valid <= 1'b0;
      end else if (pending_items.size() != 0 && idling_on && $urandom_range(0, 5) == 0) begin
        req_gap = $urandom_range(0, 6);
        req_ch.valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        req_ch.data <= pending_items.pop_front();
        req_ch.valid <= 1'b1;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // The result monitor compares every accepted body with the oldest expectation.
  always @(posedge clk) begin
    nbge_out_t want;
    nbge_out_t got;
    if (rst_n && body_ch.valid && body_ch.ready) begin
      got = body_ch.data;
      if (expected_bodies.size() == 0) begin
        $error("unexpected body item for slot %0d", got.out_slot);
        mismatch_count++;
      end else begin
        want = expected_bodies.pop_front();
        if (got.out_slot != want.out_slot) begin
          $error("out_slot expected %0d actual %0d", want.out_slot, got.out_slot);
          mismatch_count++;
        end
        if (got.new_pos_x != want.new_pos_x) begin
          $error("new_pos_x expected %0d actual %0d", want.new_pos_x, got.new_pos_x);
          mismatch_count++;
        end
        if (got.new_pos_y != want.new_pos_y) begin
          $error("new_pos_y expected %0d actual %0d", want.new_pos_y, got.new_pos_y);
          mismatch_count++;
        end
        if (got.new_pos_z != want.new_pos_z) begin
          $error("new_pos_z expected %0d actual %0d", want.new_pos_z, got.new_pos_z);
          mismatch_count++;
        end
        if (got.new_vel_x != want.new_vel_x) begin
          $error("new_vel_x expected %0d actual %0d", want.new_vel_x, got.new_vel_x);
          mismatch_count++;
        end
        if (got.new_vel_y != want.new_vel_y) begin
          $error("new_vel_y expected %0d actual %0d", want.new_vel_y, got.new_vel_y);
          mismatch_count++;
        end
        if (got.new_vel_z != want.new_vel_z) begin
          $error("new_vel_z expected %0d actual %0d", want.new_vel_z, got.new_vel_z);
          mismatch_count++;
        end
        if (got.clipped != want.clipped) begin
          $error("clipped expected %0d actual %0d", want.clipped, got.clipped);
          mismatch_count++;
        end
        if (got.last_of_run != want.last_of_run) begin
          $error("last_of_run expected %0d actual %0d", want.last_of_run, got.last_of_run);
          mismatch_count++;
        end
      end
    end
  end

  // The receiver stalls in random bursts while idling is on.
  always @(posedge clk) begin
    if (!rst_n) begin
      body_ch.ready <= 1'b0;
      body_gap = 0;
    end else if (body_gap > 0) begin
      body_gap--;
      body_ch.ready <= 1'b0;
    end else if (idling_on && $urandom_range(0, 4) == 0) begin
      body_gap = $urandom_range(0, 6);
      body_ch.ready <= 1'b0;
    end else begin
      body_ch.ready <= 1'b1;
    end
  end

  // The watchdog ends a run in which nothing has moved for too long.
  always @(posedge clk) begin
    if (!rst_n || (req_ch.valid && req_ch.ready) || (body_ch.valid && body_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // A register write has a setup phase and an access phase; the predictor follows it.
  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_GAIN: begin
        gain_q = value;
      end
      REG_DT: begin
        dt_q = value[23:0];
      end
      REG_MIN: begin
        min_sq_q = value;
      end
      default: begin
        paused_q = value[0];
      end
    endcase
  endtask

  task automatic write_all(input logic [31:0] gain, input logic [23:0] dt,
                           input logic [31:0] min_sq, input logic pause);
    write_reg(REG_GAIN, gain);
    write_reg(REG_DT, {8'd0, dt});
    write_reg(REG_MIN, min_sq);
    write_reg(REG_PAUSE, {31'd0, pause});
  endtask

  // This waits until every item is taken and every body is back, then lets the block settle.
  task automatic drain();
    do begin
      @(posedge clk);
      #1;
    end while (pending_items.size() != 0 || req_ch.valid || expected_bodies.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic nbge_in_t load_item(input int slot, input int px, input int py,
                                         input int pz, input int vx, input int vy,
                                         input int vz, input bit pin);
    nbge_in_t it;
    it.req_type = REQ_LOAD;
    it.slot = SLOT_W'(slot);
    it.load_pos_x = px;
    it.load_pos_y = py;
    it.load_pos_z = pz;
    it.load_vel_x = vx;
    it.load_vel_y = vy;
    it.load_vel_z = vz;
    it.stays_fixed = pin;
    return it;
  endfunction

  // Tick items carry random payload that the block must ignore.
  function automatic nbge_in_t tick_item();
    nbge_in_t it;
    it = load_item($urandom_range(0, 7), $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom, $urandom_range(0, 1));
    it.req_type = REQ_TICK;
    return it;
  endfunction

  // Most coordinates lie within a few units of the origin so bodies interact; some span the full range.
  function automatic int coord(input int span_bits);
    if ($urandom_range(0, 4) == 0) return int'($urandom);
    return int'($urandom_range(0, (1 << (span_bits + 1)) - 1)) - (1 << span_bits);
  endfunction

  function automatic nbge_in_t random_load();
    return load_item($urandom_range(0, 7), coord(19), coord(19), coord(19),
                     coord(17), coord(17), coord(17), $urandom_range(0, 4) == 0);
  endfunction

  initial begin
    logic [31:0] gain;
    logic [23:0] dt;
    logic [31:0] min_sq;
    rst_n = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    body_ch.ready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    mismatch_count = 0;
    idling_on = 1'b1;
    stall_cycles = 0;
    gain_q = GAIN_RST;
    dt_q = DT_RST;
    min_sq_q = MIN_RST;
    paused_q = 1'b0;
    for (int i = 0; i < MAX_BODIES; i++) begin
      body_live[i] = 1'b0;
      body_pinned[i] = 1'b0;
      for (int ax = 0; ax < 3; ax++) begin
        body_pos[i][ax] = 0;
        body_vel[i][ax] = 0;
      end
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The directed part runs first with the reset values of the registers.
    // A tick with no live body must produce nothing.
    pending_items.push_back(tick_item());
    // The field extremes: largest and smallest values, one pinned body.
    pending_items.push_back(load_item(0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                                      32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0));
    pending_items.push_back(load_item(7, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                                      32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1));
    pending_items.push_back(tick_item());
    // Two bodies share one position, so that pair sits at zero distance.
    pending_items.push_back(load_item(1, 32'h0001_0000, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(load_item(2, 32'h0001_0000, 0, 0, 0, 32'h0000_8000, 0, 0));
    // This pair is closer than the skip threshold.
    pending_items.push_back(load_item(3, 32'h0001_0100, 32'h0000_0100, 0, 0, 0, 0, 0));
    // This body lies under two units away and feels a real pull.
    pending_items.push_back(load_item(4, 0, 32'h0001_0000, 32'h0001_0000, 0, 0, 0, 0));
    pending_items.push_back(tick_item());
    // The live slot is reloaded with a pinned body.
    pending_items.push_back(load_item(0, 32'h0002_0000, 32'hFFFF_0000, 0, 0, 0, 0, 1));
    pending_items.push_back(tick_item());
    drain();
    write_all(GAIN_RST, DT_RST, MIN_RST, 1'b0);

    // A paused tick reports the state unchanged.
    write_reg(REG_PAUSE, 32'd1);
    pending_items.push_back(tick_item());
    drain();

    // The largest gain and step with no threshold drive the arithmetic toward saturation.
    write_all(32'hFFFF_FFFF, 24'hFF_FFFF, 32'd0, 1'b0);
    pending_items.push_back(tick_item());
    pending_items.push_back(tick_item());
    drain();

    // A zero gain, the smallest step and the largest threshold leave forces at zero.
    write_all(32'd0, 24'd1, 32'hFFFF_FFFF, 1'b0);
    pending_items.push_back(load_item(5, 0, 0, 32'h0003_0000, 32'h0001_0000, 0, 0, 0));
    pending_items.push_back(tick_item());
    drain();

    // The random part mixes typical settings with the extremes, phase by phase.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case ($urandom_range(0, 3))
        0: gain = GAIN_RST;
        1: gain = 32'hFFFF_FFFF;
        2: gain = 32'd0;
        default: gain = $urandom;
      endcase
      case ($urandom_range(0, 3))
        0: dt = DT_RST;
        1: dt = 24'hFF_FFFF;
        2: dt = 24'd1;
        default: dt = 24'($urandom_range(1, 24'hFF_FFFF));
      endcase
      case ($urandom_range(0, 3))
        0: min_sq = MIN_RST;
        1: min_sq = 32'd0;
        2: min_sq = $urandom;
        default: min_sq = $urandom_range(0, 32'h0001_0000);
      endcase
      write_all(gain, dt, min_sq, $urandom_range(0, 5) == 0);
      // The final phase runs without any idling on either side.
      if (ph == RANDOM_PHASES - 1) idling_on = 1'b0;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(0, 3) == 0) pending_items.push_back(tick_item());
        else pending_items.push_back(random_load());
      end
      pending_items.push_back(tick_item());
      drain();
    end

    if (expected_bodies.size() != 0) begin
      $error("%0d expected body items never arrived", expected_bodies.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+sv
sv/nbge_pkg.sv
sv/nbge_in_if.sv
sv/nbge_out_if.sv
sv/nbody_gravity_euler_step.sv
dv/testbench.sv
